// ===== hdl/rrc_pkg.sv =====
// Shared types, constants and helper functions for the rounded rectangle coverage block.
package rrc_pkg;

    // Coordinate handling: bounds and pixels use the low COORD_BITS bits
    localparam int IN_W       = 16;
    localparam int COORD_BITS = 16;
    localparam int CW         = COORD_BITS + 2;   // room for bound +/- radius

    // Corner and coverage widths
    localparam int NCORNER = 4;
    localparam int RAD_W   = 7;
    localparam int RADS_W  = NCORNER * RAD_W;
    localparam int FRAC_W  = 4;
    localparam int COV_W   = 8;
    localparam int SQ_SUM_W = 2 * RAD_W + 1;
    localparam int SQ_W    = 24;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int RD_W    = ROOT_W + 1;

    // Root pipeline: ROOT_STEPS digit steps, RSTEP_PER_STG per stage
    localparam int ROOT_STEPS    = SQ_W / 2;
    localparam int RSTEP_PER_STG = 3;
    localparam int ROOT_STG      = ROOT_STEPS / RSTEP_PER_STG;

    // Stage map: two geometry, one square, ROOT_STG root, one shade/output
    localparam int GEOM_STG  = 2;
    localparam int STG_SQ    = GEOM_STG;
    localparam int STG_SHADE = GEOM_STG + 1 + ROOT_STG;
    localparam int NSTG      = STG_SHADE + 1;
    localparam int CNT_W     = $clog2(NSTG + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RADS_W;

    localparam logic [COV_W-1:0]  COV_FULL   = 8'hFF;
    localparam logic [COV_W-1:0]  COV_NONE   = 8'h00;
    localparam logic [FRAC_W-1:0] EDGE_SOLID = 4'd15;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_RIGHT  = 3'd2,
        CFG_BOTTOM = 3'd3,
        CFG_RADII  = 3'd4,
        CFG_FRAC   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [IN_W-1:0]   left;
        logic [IN_W-1:0]   top;
        logic [IN_W-1:0]   right;
        logic [IN_W-1:0]   bottom;
        logic [RADS_W-1:0] radii;
        logic [FRAC_W-1:0] frac;
    } t_cfg;

    // Per-pixel class carried down the pipe
    typedef struct packed {
        logic             corner;   // coverage comes from the distance path
        logic [COV_W-1:0] cov;      // fixed coverage when not a corner
        logic [RAD_W-1:0] rad;      // radius of the selected corner
    } t_tag;

    // Partial state of the digit-by-digit square root
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } t_root;

    // Sign extend the low COORD_BITS bits of a coordinate
    function automatic logic signed [CW-1:0] coord_ext(input logic [IN_W-1:0] v);
        logic signed [COORD_BITS-1:0] t;
        t = v[COORD_BITS-1:0];
        return CW'(t);
    endfunction

    // One step of the restoring square root; step k tests bit 2^(SQ_W-2-2k)
    function automatic t_root root_step(input t_root s, input int unsigned k);
        t_root           o;
        logic [SQ_W-1:0] b;
        logic [SQ_W:0]   trial;
        o     = s;
        b     = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        trial = {1'b0, s.res} + {1'b0, b};
        if ({1'b0, s.rem} >= trial) begin
            o.rem = s.rem - trial[SQ_W-1:0];
            o.res = (s.res >> 1) + b;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

// ===== hdl/rrc_geom.sv =====
// Geometry stages: bound and corner tests, then corner priority and offset select.
module rrc_geom (
    input  logic                              i_clk,
    input  logic [rrc_pkg::GEOM_STG-1:0]      i_en,
    input  rrc_pkg::t_cfg                     i_cfg,
    input  logic [rrc_pkg::IN_W-1:0]          i_x,
    input  logic [rrc_pkg::IN_W-1:0]          i_y,
    output rrc_pkg::t_tag                     o_tag,
    output logic [rrc_pkg::RAD_W-1:0]         o_dx,
    output logic [rrc_pkg::RAD_W-1:0]         o_dy
);
    import rrc_pkg::*;

    logic signed [CW-1:0] x, y, lb, tb, rb, bb;
    logic signed [CW-1:0] rs [NCORNER];
    logic [RAD_W-1:0]     rad [NCORNER];
    logic signed [CW-1:0] ox [NCORNER];
    logic signed [CW-1:0] oy [NCORNER];
    logic [NCORNER-1:0]   hit;
    logic                 inb, edge_px;

    logic                 r_inb, r_edge;
    logic [NCORNER-1:0]   r_hit;
    logic [RAD_W-1:0]     r_ox [NCORNER];
    logic [RAD_W-1:0]     r_oy [NCORNER];

    t_tag                 n_tag, r_tag;
    logic [RAD_W-1:0]     n_dx, n_dy, r_dx, r_dy;

    // Stage 1: compares and offsets for all four corners in parallel
    always_comb begin
        x  = coord_ext(i_x);
        y  = coord_ext(i_y);
        lb = coord_ext(i_cfg.left);
        tb = coord_ext(i_cfg.top);
        rb = coord_ext(i_cfg.right);
        bb = coord_ext(i_cfg.bottom);
        for (int i = 0; i < NCORNER; i++) begin
            rad[i] = i_cfg.radii[i*RAD_W +: RAD_W];
            rs[i]  = $signed(CW'(rad[i]));
        end
        inb     = (x >= lb) && (x <= rb) && (y >= tb) && (y <= bb);
        edge_px = (x == lb) || (x == rb) || (y == tb) || (y == bb);
        // top-left
        ox[0]  = lb + rs[0] - x;
        oy[0]  = tb + rs[0] - y;
        hit[0] = (rad[0] != '0) && (x <= lb + rs[0]) && (y <= tb + rs[0]);
        // top-right
        ox[1]  = x + rs[1] - rb;
        oy[1]  = tb + rs[1] - y;
        hit[1] = (rad[1] != '0) && (x >= rb - rs[1]) && (y <= tb + rs[1]);
        // bottom-right
        ox[2]  = x + rs[2] - rb;
        oy[2]  = y + rs[2] - bb;
        hit[2] = (rad[2] != '0) && (x >= rb - rs[2]) && (y >= bb - rs[2]);
        // bottom-left
        ox[3]  = lb + rs[3] - x;
        oy[3]  = y + rs[3] - bb;
        hit[3] = (rad[3] != '0) && (x <= lb + rs[3]) && (y >= bb - rs[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_inb  <= inb;
            r_edge <= edge_px;
            r_hit  <= hit;
            for (int i = 0; i < NCORNER; i++) begin
                // inside a matched corner square the offsets are 0..r
                r_ox[i] <= ox[i][RAD_W-1:0];
                r_oy[i] <= oy[i][RAD_W-1:0];
            end
        end
    end

    // Stage 2: first matching corner wins, else edge or interior
    always_comb begin
        n_tag.corner = 1'b0;
        n_tag.cov    = COV_FULL;
        n_tag.rad    = '0;
        n_dx         = '0;
        n_dy         = '0;
        if (!r_inb) begin
            n_tag.cov = COV_NONE;
        end else if (r_hit != '0) begin
            n_tag.corner = 1'b1;
            for (int i = NCORNER - 1; i >= 0; i--) begin
                if (r_hit[i]) begin
                    n_tag.rad = i_cfg.radii[i*RAD_W +: RAD_W];
                    n_dx      = r_ox[i];
                    n_dy      = r_oy[i];
                end
            end
        end else if (r_edge && (i_cfg.frac != EDGE_SOLID)) begin
            n_tag.cov = {i_cfg.frac, i_cfg.frac};   // frac * 17
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_tag <= n_tag;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
        end
    end

    assign o_tag = r_tag;
    assign o_dx  = r_dx;
    assign o_dy  = r_dy;

endmodule

// ===== hdl/rrc_dist.sv =====
// Distance stages: squared offset sum, then a pipelined square root of 256 times it.
module rrc_dist (
    input  logic                            i_clk,
    input  logic [rrc_pkg::ROOT_STG:0]      i_en,
    input  rrc_pkg::t_tag                   i_tag,
    input  logic [rrc_pkg::RAD_W-1:0]       i_dx,
    input  logic [rrc_pkg::RAD_W-1:0]       i_dy,
    output rrc_pkg::t_tag                   o_tag,
    output logic [rrc_pkg::ROOT_W-1:0]      o_root
);
    import rrc_pkg::*;

    logic [2*RAD_W-1:0]  dx_sq, dy_sq;
    logic [SQ_SUM_W-1:0] sq_sum;

    t_root r_st  [ROOT_STG+1];
    t_tag  r_tag [ROOT_STG+1];

    // Square stage: dx^2 + dy^2, scaled by 256 for a result in sixteenths
    always_comb begin
        dx_sq  = i_dx * i_dx;
        dy_sq  = i_dy * i_dy;
        sq_sum = SQ_SUM_W'(dx_sq) + SQ_SUM_W'(dy_sq);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_st[0].rem <= SQ_W'({sq_sum, 8'h00});
            r_st[0].res <= '0;
            r_tag[0]    <= i_tag;
        end
    end

    // Root stages: RSTEP_PER_STG digit steps each
    for (genvar g = 0; g < ROOT_STG; g++) begin : g_root
        t_root n_st;

        always_comb begin
            n_st = r_st[g];
            for (int k = 0; k < RSTEP_PER_STG; k++) begin
                n_st = root_step(n_st, g * RSTEP_PER_STG + k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[g+1]) begin
                r_st[g+1]  <= n_st;
                r_tag[g+1] <= r_tag[g];
            end
        end
    end

    assign o_tag  = r_tag[ROOT_STG];
    assign o_root = r_st[ROOT_STG].res[ROOT_W-1:0];

endmodule

// ===== hdl/rrc_shade.sv =====
// Shade stage: corner distance to alpha, output register.
module rrc_shade (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rrc_pkg::FRAC_W-1:0]      i_frac,
    input  rrc_pkg::t_tag                   i_tag,
    input  logic [rrc_pkg::ROOT_W-1:0]      i_root,
    output logic [rrc_pkg::COV_W-1:0]       o_cov
);
    import rrc_pkg::*;

    logic [RAD_W+FRAC_W-1:0] reach;
    logic [RD_W-1:0]         rd;
    logic [COV_W-1:0]        n_cov, r_cov;

    // rd = 16r + frac - root, signed in RD_W bits
    always_comb begin
        reach = {i_tag.rad, FRAC_W'(0)} + (RAD_W+FRAC_W)'(i_frac);
        rd    = RD_W'(reach) - RD_W'(i_root);
        if (!i_tag.corner) begin
            n_cov = i_tag.cov;
        end else if (rd[RD_W-1]) begin
            n_cov = COV_NONE;
        end else if (rd[RD_W-2:FRAC_W] != '0) begin
            n_cov = COV_FULL;
        end else begin
            n_cov = {rd[FRAC_W-1:0], rd[FRAC_W-1:0]};   // rd * 17
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cov <= n_cov;
        end
    end

    assign o_cov = r_cov;

endmodule

// ===== hdl/rounded_rect_coverage_alpha.sv =====
// Top level: antialiased rounded rectangle coverage, config registers and pipeline control.
//
//  Channel   Direction  Word                                  Handshake
//  s_*       in         tdata[15:0] pixel_x, [31:16] pixel_y  tvalid/tready
//  m_*       out        tdata[7:0] coverage                   tvalid/tready
//  cfg_*     in         addr = register index, data = value   valid/ready
//
// One pixel per clock while the output is not stalled, through eight register stages
// (two geometry, one square, four root stages of three digit steps each, one
// shade/output stage). Every stage has its own valid bit and takes a new word when
// it is empty or its successor moves, so bubbles close up under an output stall.
// Reset clears all valid bits and loads the config reset values.
// Config writes are always taken and ignored for unknown indexes.
module rounded_rect_coverage_alpha (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel stream in
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [2*rrc_pkg::IN_W-1:0]       i_s_tdata,   // [15:0] pixel_x, [31:16] pixel_y
    // coverage stream out
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [rrc_pkg::COV_W-1:0]        o_m_tdata,   // [7:0] coverage
    // config write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rrc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [rrc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rrc_pkg::*;

    t_cfg              r_cfg;
    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   en;
    logic [CNT_W-1:0]  r_inflight;
    t_tag              geom_tag, dist_tag;
    logic [RAD_W-1:0]  geom_dx, geom_dy;
    logic [ROOT_W-1:0] dist_root;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left   <= '0;
            r_cfg.top    <= '0;
            r_cfg.right  <= '0;
            r_cfg.bottom <= '0;
            r_cfg.radii  <= '0;
            r_cfg.frac   <= EDGE_SOLID;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_LEFT:   r_cfg.left   <= i_cfg_data[IN_W-1:0];
                CFG_TOP:    r_cfg.top    <= i_cfg_data[IN_W-1:0];
                CFG_RIGHT:  r_cfg.right  <= i_cfg_data[IN_W-1:0];
                CFG_BOTTOM: r_cfg.bottom <= i_cfg_data[IN_W-1:0];
                CFG_RADII:  r_cfg.radii  <= i_cfg_data[RADS_W-1:0];
                CFG_FRAC:   r_cfg.frac   <= i_cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[NSTG-1];

    // Valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Words inside the pipe, for checking only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(i_s_tvalid && o_s_tready)
                                     - CNT_W'(o_m_tvalid && i_m_tready);
        end
    end

    rrc_geom u_geom (
        .i_clk (i_clk),
        .i_en  (en[GEOM_STG-1:0]),
        .i_cfg (r_cfg),
        .i_x   (i_s_tdata[IN_W-1:0]),
        .i_y   (i_s_tdata[2*IN_W-1:IN_W]),
        .o_tag (geom_tag),
        .o_dx  (geom_dx),
        .o_dy  (geom_dy)
    );

    rrc_dist u_dist (
        .i_clk  (i_clk),
        .i_en   (en[STG_SHADE-1:STG_SQ]),
        .i_tag  (geom_tag),
        .i_dx   (geom_dx),
        .i_dy   (geom_dy),
        .o_tag  (dist_tag),
        .o_root (dist_root)
    );

    rrc_shade u_shade (
        .i_clk  (i_clk),
        .i_en   (en[STG_SHADE]),
        .i_frac (r_cfg.frac),
        .i_tag  (dist_tag),
        .i_root (dist_root),
        .o_cov  (o_m_tdata)
    );

    // Every accepted word is in exactly one valid stage until delivered
    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == CNT_W'($countones(r_vld)))
        else $error("pipeline valid bits disagree with words in flight");

    // A full, stalled pipe must refuse input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while pipeline full and stalled");

    // Output valid only appears behind a valid word in the last root stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_vld[NSTG-2]))
        else $error("output valid without a word behind it");

endmodule
